### src/address_translation_table_assert.svh
`ifndef ADDRESS_TRANSLATION_TABLE_ASSERT_SVH
`define ADDRESS_TRANSLATION_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ATT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("address translation table: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ATT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("address translation table: next-cycle check failed");

`endif

### src/att_pkg.sv
package att_pkg;

    // Default table size
    localparam int unsigned TABLE_DEPTH_DEF = 16;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned TAG_W  = 6;
    localparam int unsigned REQ_W  = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_MAP    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TYPE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

    // Coprocessor address that marks "no coprocessor object"
    localparam logic [ADDR_W-1:0] NO_COPRO_MARK = '1;

    // One table entry
    typedef struct packed {
        logic [ADDR_W-1:0]       copro_addr;
        logic [ADDR_W-1:0]       main_addr;
        logic signed [TAG_W-1:0] type_tag;
    } entry_t;

endpackage

### src/att_mem.sv
module att_mem #(
    parameter int unsigned TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF,
    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  att_pkg::entry_t   wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output att_pkg::entry_t   rd_data
);
    import att_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    // Single write port, single registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/att_ctrl.sv
module att_ctrl #(
    parameter int unsigned TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF,
    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request side
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [att_pkg::REQ_W-1:0]        s_req_type,
    input  logic [att_pkg::ADDR_W-1:0]       s_main_addr,
    input  logic [att_pkg::ADDR_W-1:0]       s_copro_addr_in,
    input  logic signed [att_pkg::TAG_W-1:0] s_type_tag_in,
    // result side
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_status,
    output logic                             m_found,
    output logic [att_pkg::ADDR_W-1:0]       m_copro_addr_out,
    output logic signed [att_pkg::TAG_W-1:0] m_type_tag_out,
    // table memory
    output logic                             mem_wr_en,
    output logic [IDX_W-1:0]                 mem_wr_addr,
    output att_pkg::entry_t                  mem_wr_data,
    output logic                             mem_rd_en,
    output logic [IDX_W-1:0]                 mem_rd_addr,
    input  att_pkg::entry_t                  mem_rd_data
);
    import att_pkg::*;

    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;

    logic [REQ_W-1:0]        req_reg, req_next;
    logic [ADDR_W-1:0]       main_reg, main_next;
    logic [ADDR_W-1:0]       copro_reg, copro_next;
    logic signed [TAG_W-1:0] tag_reg, tag_next;

    logic                    res_status_reg, res_status_next;
    logic                    res_found_reg, res_found_next;
    logic [ADDR_W-1:0]       res_copro_reg, res_copro_next;
    logic signed [TAG_W-1:0] res_tag_reg, res_tag_next;

    logic                    m_valid_reg, m_valid_next;
    logic                    m_status_reg, m_status_next;
    logic                    m_found_reg, m_found_next;
    logic [ADDR_W-1:0]       m_copro_reg, m_copro_next;
    logic signed [TAG_W-1:0] m_tag_reg, m_tag_next;

    logic entry_hit;
    logic more_entries;
    logic table_full;
    logic out_free;

    // Compare the entry read last cycle against the request key
    always_comb begin
        entry_hit = cmp_valid_reg &&
                    ((mem_rd_data.main_addr == main_reg) ||
                     ((req_reg == REQ_MAP) && (mem_rd_data.copro_addr == copro_reg)) ||
                     ((req_reg == REQ_TYPE) && (mem_rd_data.copro_addr == NO_COPRO_MARK)));
    end

    assign more_entries = (rd_idx_reg != count_reg);
    assign table_full   = (count_reg == CNT_FULL);
    assign out_free     = !m_valid_reg || m_ready;

    // Sequencer: accept, walk the table, update, hand off result
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        req_next        = req_reg;
        main_next       = main_reg;
        copro_next      = copro_reg;
        tag_next        = tag_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_copro_next  = res_copro_reg;
        res_tag_next    = res_tag_reg;
        s_ready         = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = cmp_idx_reg;
        mem_wr_data     = '{copro_addr: copro_reg, main_addr: main_reg, type_tag: tag_reg};
        mem_rd_en       = 1'b0;
        mem_rd_addr     = rd_idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next        = s_req_type;
                    main_next       = s_main_addr;
                    copro_next      = s_copro_addr_in;
                    tag_next        = s_type_tag_in;
                    res_status_next = 1'b0;
                    res_found_next  = 1'b0;
                    res_copro_next  = '0;
                    res_tag_next    = '0;
                    rd_idx_next     = '0;
                    cmp_valid_next  = 1'b0;
                    if (s_req_type == REQ_MAP || s_req_type == REQ_TYPE ||
                        s_req_type == REQ_LOOKUP) begin
                        state_next = ST_SCAN;
                    end else begin
                        // unused code: no change, all-zero result
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (entry_hit) begin
                    res_found_next = 1'b1;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_DONE;
                    if (req_reg == REQ_MAP) begin
                        mem_wr_en = 1'b1;
                    end else if (req_reg == REQ_TYPE) begin
                        // keep addresses, rewrite the tag only
                        mem_wr_en   = 1'b1;
                        mem_wr_data = '{copro_addr: mem_rd_data.copro_addr,
                                        main_addr:  mem_rd_data.main_addr,
                                        type_tag:   tag_reg};
                    end else begin
                        res_copro_next = mem_rd_data.copro_addr;
                        res_tag_next   = mem_rd_data.type_tag;
                    end
                end else if (more_entries) begin
                    // issue the next read, one entry per cycle
                    mem_rd_en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                end else begin
                    // miss: append for register requests
                    cmp_valid_next = 1'b0;
                    state_next     = ST_DONE;
                    if (req_reg != REQ_LOOKUP) begin
                        if (table_full) begin
                            res_status_next = 1'b1;
                        end else begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = count_reg[IDX_W-1:0];
                            if (req_reg == REQ_TYPE) begin
                                mem_wr_data = '{copro_addr: '0, main_addr: main_reg,
                                                type_tag: tag_reg};
                            end
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_copro_next  = m_copro_reg;
        m_tag_next    = m_tag_reg;
        if (state_reg == ST_DONE && out_free) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_found_next  = res_found_reg;
            m_copro_next  = res_copro_reg;
            m_tag_next    = res_tag_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        req_reg        <= req_next;
        main_reg       <= main_next;
        copro_reg      <= copro_next;
        tag_reg        <= tag_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_copro_reg  <= res_copro_next;
        res_tag_reg    <= res_tag_next;
        m_status_reg   <= m_status_next;
        m_found_reg    <= m_found_next;
        m_copro_reg    <= m_copro_next;
        m_tag_reg      <= m_tag_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found          = m_found_reg;
    assign m_copro_addr_out = m_copro_reg;
    assign m_type_tag_out   = m_tag_reg;

endmodule

### src/address_translation_table.sv
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | req_type, main_addr, copro_addr_in, type_tag_in
// m_       | out       | m_valid / m_ready  | status, found, copro_addr_out, type_tag_out
//
// One request at a time; the walk covers at most the fill count of entries,
// fewer on an early hit, and reads one entry per cycle through the table
// memory's single read port.
// An unused request code skips the walk.
// Reset clears the fill count and the handshake state only; no clearing pass.
// A result waiting on m_ready does not stop the next request from being taken.
module address_translation_table #(
    parameter int unsigned TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [att_pkg::REQ_W-1:0]        s_req_type,
    input  logic [att_pkg::ADDR_W-1:0]       s_main_addr,
    input  logic [att_pkg::ADDR_W-1:0]       s_copro_addr_in,
    input  logic signed [att_pkg::TAG_W-1:0] s_type_tag_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_status,
    output logic                             m_found,
    output logic [att_pkg::ADDR_W-1:0]       m_copro_addr_out,
    output logic signed [att_pkg::TAG_W-1:0] m_type_tag_out
);
    import att_pkg::*;

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    entry_t           mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    entry_t           mem_rd_data;

    // Sequencer and output register
    att_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_main_addr     (s_main_addr),
        .s_copro_addr_in (s_copro_addr_in),
        .s_type_tag_in   (s_type_tag_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found         (m_found),
        .m_copro_addr_out(m_copro_addr_out),
        .m_type_tag_out  (m_type_tag_out),
        .mem_wr_en       (mem_wr_en),
        .mem_wr_addr     (mem_wr_addr),
        .mem_wr_data     (mem_wr_data),
        .mem_rd_en       (mem_rd_en),
        .mem_rd_addr     (mem_rd_addr),
        .mem_rd_data     (mem_rd_data)
    );

    // Entry storage
    att_mem #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_mem (
        .aclk   (aclk),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data),
        .rd_en  (mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data)
    );

endmodule

### src/att_checker.sv
`include "address_translation_table_assert.svh"

module att_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic                             m_status,
    input logic                             m_found,
    input logic [att_pkg::ADDR_W-1:0]       m_copro_addr_out,
    input logic signed [att_pkg::TAG_W-1:0] m_type_tag_out
);
    logic       s_fire;
    logic       m_fire;
    logic [1:0] pending_reg, pending_next;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    // Requests taken but not yet answered
    always_comb begin
        pending_next = pending_reg;
        if (s_fire && !m_fire) begin
            pending_next = pending_reg + 2'd1;
        end else if (m_fire && !s_fire) begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // A result must be backed by an accepted request
    `ATT_ASSERT_NOW(a_no_spurious_result, aclk, aresetn, m_valid, pending_reg != 2'd0)
    // Only one request in the table walk at a time
    `ATT_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_fire, !s_ready)
    // A refused append reports nothing else
    `ATT_ASSERT_NOW(a_full_is_clean, aclk, aresetn, m_valid && m_status, !m_found && m_copro_addr_out == '0 && m_type_tag_out == '0)
    // A translated address only comes from a lookup hit
    `ATT_ASSERT_NOW(a_addr_needs_hit, aclk, aresetn, m_valid && m_copro_addr_out != '0, m_found && !m_status)
    // Stalled result holds its valid, found flag and coprocessor address
    `ATT_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_copro_addr_out) && $stable(m_found))

endmodule

bind address_translation_table att_checker u_att_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import att_pkg::*;

    localparam int unsigned DEPTH = TABLE_DEPTH_DEF;
    // Request code with no defined action
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 1000;
    localparam int HOLD_AFTER_REQS = 300;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [REQ_W-1:0]       kind;
        logic [ADDR_W-1:0]      main;
        logic [ADDR_W-1:0]      copro;
        logic signed [TAG_W-1:0] tag;
    } xlat_req_t;

    typedef struct {
        logic                    status;
        logic                    found;
        logic [ADDR_W-1:0]       copro;
        logic signed [TAG_W-1:0] tag;
    } xlat_reply_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [REQ_W-1:0] s_req_type = '0;
    logic [ADDR_W-1:0] s_main_addr = '0;
    logic [ADDR_W-1:0] s_copro_addr_in = '0;
    logic signed [TAG_W-1:0] s_type_tag_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_status;
    logic m_found;
    logic [ADDR_W-1:0] m_copro_addr_out;
    logic signed [TAG_W-1:0] m_type_tag_out;

    address_translation_table uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_main_addr(s_main_addr),
        .s_copro_addr_in(s_copro_addr_in),
        .s_type_tag_in(s_type_tag_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_found(m_found),
        .m_copro_addr_out(m_copro_addr_out),
        .m_type_tag_out(m_type_tag_out)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 0;
    end

    // Shadow copy of the translation table
    logic [ADDR_W-1:0]       shadow_copro [DEPTH];
    logic [ADDR_W-1:0]       shadow_main [DEPTH];
    logic signed [TAG_W-1:0] shadow_tag [DEPTH];
    int unsigned             shadow_fill = 0;

    xlat_req_t   outgoing_requests[$];
    xlat_reply_t predicted_replies[$];
    logic [ADDR_W-1:0] known_main[$];
    logic [ADDR_W-1:0] known_copro[$];

    int mismatches = 0;
    int accepted_reqs = 0;
    int checked_replies = 0;
    int n_hits = 0;
    int n_appends = 0;
    int n_refused = 0;
    int n_lookup_miss = 0;

    // First matching slot in insertion order, -1 when none matches
    function automatic int find_slot(bit match_copro, logic [ADDR_W-1:0] copro,
                                     logic [ADDR_W-1:0] key);
        for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_main[i] == key) return i;
            if (match_copro && shadow_copro[i] == copro) return i;
        end
        return -1;
    endfunction

    // Append to the shadow table; returns the full status bit
    function automatic logic append_slot(logic [ADDR_W-1:0] copro, logic [ADDR_W-1:0] key,
                                         logic signed [TAG_W-1:0] tag);
        if (shadow_fill >= DEPTH) begin
            n_refused++;
            return 1'b1;
        end
        shadow_copro[shadow_fill] = copro;
        shadow_main[shadow_fill] = key;
        shadow_tag[shadow_fill] = tag;
        shadow_fill++;
        n_appends++;
        return 1'b0;
    endfunction

    // Apply one request to the shadow table and return the reply it should give
    function automatic xlat_reply_t apply_table_request(xlat_req_t r);
        xlat_reply_t rep;
        int slot;
        rep = '{status: 1'b0, found: 1'b0, copro: '0, tag: '0};
        case (r.kind)
            REQ_MAP: begin
                slot = find_slot(1'b1, r.copro, r.main);
                if (slot >= 0) begin
                    rep.found = 1'b1;
                    shadow_tag[slot] = r.tag;
                    shadow_main[slot] = r.main;
                    shadow_copro[slot] = r.copro;
                    n_hits++;
                end else begin
                    rep.status = append_slot(r.copro, r.main, r.tag);
                end
            end
            REQ_TYPE: begin
                // entries still lacking a coprocessor object also match
                slot = find_slot(1'b1, NO_COPRO_MARK, r.main);
                if (slot >= 0) begin
                    rep.found = 1'b1;
                    shadow_tag[slot] = r.tag;
                    n_hits++;
                end else begin
                    rep.status = append_slot('0, r.main, r.tag);
                end
            end
            REQ_LOOKUP: begin
                slot = find_slot(1'b0, '0, r.main);
                if (slot >= 0) begin
                    rep.found = 1'b1;
                    rep.copro = shadow_copro[slot];
                    rep.tag = shadow_tag[slot];
                    n_hits++;
                end else begin
                    n_lookup_miss++;
                end
            end
            default: begin
            end
        endcase
        return rep;
    endfunction

    task automatic check_field(string fname, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h got %0h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_request(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] key,
                                 logic [ADDR_W-1:0] copro, int tag);
        xlat_req_t r;
        r.kind = kind;
        r.main = key;
        r.copro = copro;
        r.tag = TAG_W'(tag);
        outgoing_requests.push_back(r);
        known_main.push_back(key);
        known_copro.push_back(copro);
    endtask

    function automatic int random_tag();
        return int'($urandom_range(0, 47)) - 16;
    endfunction

    // Mostly keys seen before, now and then a fresh one
    function automatic logic [ADDR_W-1:0] pick_main();
        logic [ADDR_W-1:0] v;
        if (known_main.size() == 0 || $urandom_range(0, 99) < 4) begin
            v = $urandom;
            known_main.push_back(v);
        end else begin
            v = known_main[$urandom_range(0, known_main.size() - 1)];
        end
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_copro();
        logic [ADDR_W-1:0] v;
        int p;
        p = $urandom_range(0, 99);
        if (p < 10) begin
            v = NO_COPRO_MARK;
        end else if (p < 20) begin
            v = '0;
        end else if (p < 28 || known_copro.size() == 0) begin
            v = $urandom;
            known_copro.push_back(v);
        end else begin
            v = known_copro[$urandom_range(0, known_copro.size() - 1)];
        end
        return v;
    endfunction

    task automatic add_random_request();
        xlat_req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        r.main = pick_main();
        r.copro = pick_copro();
        r.tag = TAG_W'(random_tag());
        if (pick < 35) begin
            r.kind = REQ_LOOKUP;
        end else if (pick < 65) begin
            r.kind = REQ_MAP;
        end else if (pick < 90) begin
            r.kind = REQ_TYPE;
        end else if (pick < 95) begin
            r.kind = REQ_UNUSED;
        end else begin
            // noise: any code, unrelated addresses
            r.kind = REQ_W'($urandom_range(0, 3));
            r.main = $urandom;
            r.copro = $urandom;
        end
        outgoing_requests.push_back(r);
    endtask

    // Sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        xlat_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (outgoing_requests.size() != 0) begin
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(1, 12);
                end
                nxt = outgoing_requests.pop_front();
                s_req_type <= nxt.kind;
                s_main_addr <= nxt.main;
                s_copro_addr_in <= nxt.copro;
                s_type_tag_in <= nxt.tag;
                s_valid <= 1'b1;
                burst_left--;
                if (burst_left == 0) begin
                    gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: rotating stall mask, plus one long hold-off to back up the block
    logic [15:0] ready_mask = 16'hffff;
    int ready_phase = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_phase = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && accepted_reqs >= HOLD_AFTER_REQS) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ready_mask[ready_phase];
            ready_phase = (ready_phase + 1) % 16;
            if (ready_phase == 0 && $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_mask = 16'hffff;
                    1: ready_mask = 16'($urandom) & 16'($urandom);
                    default: ready_mask = 16'($urandom);
                endcase
            end
        end
    end

    // Monitor: predict on request accept, check on reply accept
    always @(posedge aclk) begin
        xlat_req_t got_req;
        xlat_reply_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                got_req.kind = s_req_type;
                got_req.main = s_main_addr;
                got_req.copro = s_copro_addr_in;
                got_req.tag = s_type_tag_in;
                predicted_replies.push_back(apply_table_request(got_req));
                accepted_reqs++;
            end
            if (m_valid && m_ready) begin
                if (predicted_replies.size() == 0) begin
                    $display("%0t ns: reply with no request pending, expected none got %0h/%0h/%0h/%0h",
                             $time, m_status, m_found, m_copro_addr_out, m_type_tag_out);
                    mismatches++;
                end else begin
                    want = predicted_replies.pop_front();
                    check_field("status", ADDR_W'(want.status), ADDR_W'(m_status));
                    check_field("found", ADDR_W'(want.found), ADDR_W'(m_found));
                    check_field("copro_addr_out", want.copro, m_copro_addr_out);
                    check_field("type_tag_out", {26'b0, want.tag}, {26'b0, m_type_tag_out});
                    checked_replies++;
                end
            end
        end
    end

    initial begin
        // Directed: empty table, unused code, marker and zero coprocessor addresses
        queue_request(REQ_LOOKUP, 32'h0000_0000, 32'h0, 0);
        queue_request(REQ_UNUSED, 32'hffff_ffff, 32'hffff_ffff, -1);
        queue_request(REQ_MAP, 32'h0000_0000, NO_COPRO_MARK, -16);
        queue_request(REQ_LOOKUP, 32'h0000_0000, 32'h0, 0);
        queue_request(REQ_TYPE, 32'h1234_5678, 32'h0, 31);
        queue_request(REQ_LOOKUP, 32'h0000_0000, 32'h0, 0);
        queue_request(REQ_LOOKUP, 32'h1234_5678, 32'h0, 0);
        queue_request(REQ_MAP, 32'hffff_ffff, 32'h0000_0000, 0);
        queue_request(REQ_MAP, 32'h0000_0000, 32'h0000_1000, 5);
        queue_request(REQ_TYPE, 32'ha5a5_a5a5, 32'h0, -1);
        queue_request(REQ_MAP, 32'h5a5a_5a5a, 32'h0000_0000, 7);
        queue_request(REQ_LOOKUP, 32'hffff_ffff, 32'h0, 0);
        queue_request(REQ_LOOKUP, 32'h5a5a_5a5a, 32'h0, 0);
        queue_request(REQ_LOOKUP, 32'ha5a5_a5a5, 32'h0, 0);
        queue_request(REQ_TYPE, 32'ha5a5_a5a5, 32'h0, 10);
        queue_request(REQ_MAP, 32'h0000_0001, 32'h7fff_ffff, 30);
        queue_request(REQ_LOOKUP, 32'h0000_0001, 32'h0, 0);
        queue_request(REQ_UNUSED, 32'h0000_0000, 32'h0, 0);
        queue_request(REQ_MAP, 32'h8000_0000, 32'h0000_1000, 2);
        queue_request(REQ_LOOKUP, 32'h0000_0000, 32'h0, 0);
        queue_request(REQ_LOOKUP, 32'h8000_0000, 32'h0, 0);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            add_random_request();
        end

        // Fresh keys until the table is surely full, then refused appends
        for (int i = 0; i < DEPTH + 1; i++) begin
            queue_request(REQ_MAP, $urandom, $urandom, random_tag());
        end
        queue_request(REQ_TYPE, $urandom, 32'h0, random_tag());
        queue_request(REQ_LOOKUP, $urandom, 32'h0, 0);
        queue_request(REQ_LOOKUP, 32'h8000_0000, 32'h0, 0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (outgoing_requests.size() != 0 || s_valid || predicted_replies.size() != 0) begin
            @(posedge aclk);
        end
        // let any stray reply show up
        repeat (40) @(posedge aclk);

        $display("requests %0d, replies checked %0d, hits %0d", accepted_reqs,
                 checked_replies, n_hits);
        $display("appends %0d, refused on full table %0d, lookup misses %0d",
                 n_appends, n_refused, n_lookup_miss);
        if (mismatches == 0) begin
            $display("address_translation_table: match");
        end else begin
            $display("address_translation_table: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d replies still pending", predicted_replies.size());
        $display("address_translation_table: mismatch");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/att_pkg.sv
src/att_mem.sv
src/att_ctrl.sv
src/address_translation_table.sv
src/att_checker.sv
verif/testbench.sv
